@@ src/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

    // field widths of the channels
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 11;
    localparam int POS_W      = 11;
    localparam int COLOR_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COLOR_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PRINT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // control characters
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;

    localparam int TAB_STEP = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BG = 1'd1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [2:0] {
        K_NOP,
        K_PRINT,
        K_TAB,
        K_NEWLINE,
        K_BACKSPACE,
        K_CLEAR,
        K_READ
    } tcw_kind_t;

    typedef struct packed {
        tcw_kind_t          kind;
        logic [CHAR_W-1:0]  ch;
        logic [IDX_W-1:0]   idx;
    } tcw_op_t;

    typedef struct packed {
        logic [COLOR_W-1:0] bg;
        logic [COLOR_W-1:0] fg;
        logic [CHAR_W-1:0]  ch;
    } tcw_cell_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_WIPE,
        ST_BS_RD,
        ST_BS_CHK,
        ST_DONE
    } tcw_state_t;

endpackage

`default_nettype wire

@@ src/tcw_cmd_if.sv @@
`default_nettype none

interface tcw_cmd_if;
    import tcw_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [CHAR_W-1:0]  char_code;
    logic [IDX_W-1:0]   cell_index;

    modport source (output valid, output command, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input command, input char_code, input cell_index,
                    output ready);
endinterface

`default_nettype wire

@@ src/tcw_rsp_if.sv @@
`default_nettype none

interface tcw_rsp_if;
    import tcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    cursor_position;
    logic [CHAR_W-1:0]   cell_char;
    logic [COLOR_W-1:0]  cell_fg;
    logic [COLOR_W-1:0]  cell_bg;
    logic                scrolled;

    modport source (output valid, output cursor_position, output cell_char,
                    output cell_fg, output cell_bg, output scrolled, input ready);
    modport sink   (input valid, input cursor_position, input cell_char,
                    input cell_fg, input cell_bg, input scrolled, output ready);
endinterface

`default_nettype wire

@@ src/tcw_front.sv @@
`default_nettype none

module tcw_front #(
    parameter int CELLS = 2000
) (
    tcw_cmd_if.sink          cmd,
    input  logic             q_full,
    input  logic             init_busy,
    output logic             q_push,
    output tcw_pkg::tcw_op_t q_data
);
    import tcw_pkg::*;

    localparam int RB_W = $clog2(CELLS + 1);
    localparam int XW   = (RB_W > IDX_W) ? RB_W : IDX_W;

    logic [XW-1:0] idx_x;
    logic          in_range;

    assign cmd.ready = !q_full && !init_busy;
    assign q_push    = cmd.valid && cmd.ready;

    assign idx_x    = XW'(cmd.cell_index);
    assign in_range = (idx_x < XW'(CELLS));

    always_comb
    begin
        q_data.ch  = cmd.char_code;
        q_data.idx = cmd.cell_index;
        unique case (cmd.command)
            CMD_PRINT:
            begin
                unique case (cmd.char_code)
                    CH_NUL:  q_data.kind = K_NOP;
                    CH_BS:   q_data.kind = K_BACKSPACE;
                    CH_TAB:  q_data.kind = K_TAB;
                    CH_LF:   q_data.kind = K_NEWLINE;
                    default: q_data.kind = K_PRINT;
                endcase
            end
            CMD_CLEAR: q_data.kind = K_CLEAR;
            // out-of-range reads report zeros, same as a no-op
            CMD_READ:  q_data.kind = in_range ? K_READ : K_NOP;
            default:   q_data.kind = K_NOP;
        endcase
    end

endmodule

`default_nettype wire

@@ src/tcw_queue.sv @@
`default_nettype none

module tcw_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tcw_pkg::tcw_op_t din,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output tcw_pkg::tcw_op_t dout
);
    import tcw_pkg::*;

    tcw_op_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign valid   = (count_reg != '0);
    assign dout    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

@@ src/tcw_back.sv @@
`default_nettype none

module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  tcw_pkg::tcw_op_t            q_data,
    output logic                        q_pop,
    input  logic [tcw_pkg::COLOR_W-1:0] fg,
    input  logic [tcw_pkg::COLOR_W-1:0] bg,
    output logic                        init_busy,
    tcw_rsp_if.source                   rsp
);
    import tcw_pkg::*;

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int AW       = $clog2(CELLS);
    localparam int RB_W     = $clog2(CELLS + 1);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int LAST_ROW = CELLS - COLUMNS;

    tcw_cell_t           screen_mem [CELLS];
    tcw_cell_t           rdata_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    tcw_cell_t           mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;

    tcw_state_t          state_reg, state_next;
    logic [RB_W-1:0]     row_base_reg, row_base_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [RB_W-1:0]     ptr_reg, ptr_next;
    logic                pend_reg, pend_next;
    logic                rsp_valid_reg, rsp_valid_next;
    tcw_kind_t           kind_reg, kind_next;
    logic                seek_reg, seek_next;
    logic                scrolled_reg, scrolled_next;
    logic [AW-1:0]       dst_reg, dst_next;
    logic [POS_W-1:0]    pos_out_reg, pos_out_next;
    tcw_cell_t           cell_out_reg, cell_out_next;
    logic                scr_out_reg, scr_out_next;

    logic [RB_W-1:0]     cursor;
    logic [AW-1:0]       cursor_addr;
    logic [COL_W:0]      col_inc;
    logic                wrap;
    logic [COL_W-1:0]    col_adv;
    logic [RB_W-1:0]     rb_adv;
    logic                load_out;

    // cursor kept as row start plus column, so newline needs no divide
    assign cursor      = row_base_reg + RB_W'(col_reg);
    assign cursor_addr = cursor[AW-1:0];
    assign rb_adv      = row_base_reg + RB_W'(COLUMNS);
    assign col_inc     = {1'b0, col_reg}
                       + ((q_data.kind == K_TAB) ? (COL_W+1)'(TAB_STEP) : (COL_W+1)'(1));
    assign wrap        = (q_data.kind == K_NEWLINE) || (col_inc >= (COL_W+1)'(COLUMNS));
    assign col_adv     = (q_data.kind == K_NEWLINE) ? '0
                       : wrap ? COL_W'(col_inc - (COL_W+1)'(COLUMNS))
                       : col_inc[COL_W-1:0];

    assign init_busy = (state_reg == ST_INIT);
    assign load_out  = (state_reg == ST_DONE) && (!rsp_valid_reg || rsp.ready);

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.cursor_position = pos_out_reg;
    assign rsp.cell_char       = cell_out_reg.ch;
    assign rsp.cell_fg         = cell_out_reg.fg;
    assign rsp.cell_bg         = cell_out_reg.bg;
    assign rsp.scrolled        = scr_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        row_base_next  = row_base_reg;
        col_next       = col_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        kind_next      = kind_reg;
        seek_next      = seek_reg;
        scrolled_next  = scrolled_reg;
        dst_next       = dst_reg;
        pos_out_next   = pos_out_reg;
        cell_out_next  = cell_out_reg;
        scr_out_next   = scr_out_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[AW-1:0];
                if (ptr_reg == RB_W'(CELLS - 1))
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop         = 1'b1;
                    kind_next     = q_data.kind;
                    scrolled_next = 1'b0;
                    unique case (q_data.kind) inside
                        K_PRINT, K_TAB, K_NEWLINE:
                        begin
                            if (q_data.kind == K_PRINT)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cursor_addr;
                                mem_wdata = '{bg: bg, fg: fg, ch: q_data.ch};
                            end
                            col_next   = col_adv;
                            state_next = ST_DONE;
                            if (wrap)
                            begin
                                if (rb_adv == RB_W'(CELLS))
                                begin
                                    // ran off the end: move rows up, cursor to last row
                                    row_base_next = RB_W'(LAST_ROW);
                                    col_next      = '0;
                                    ptr_next      = RB_W'(COLUMNS);
                                    pend_next     = 1'b0;
                                    scrolled_next = 1'b1;
                                    state_next    = ST_SCROLL;
                                end
                                else
                                begin
                                    row_base_next = rb_adv;
                                end
                            end
                        end
                        K_BACKSPACE:
                        begin
                            seek_next = (col_reg == '0);
                            if (cursor != '0)
                            begin
                                if (col_reg == '0)
                                begin
                                    col_next      = COL_W'(COLUMNS - 1);
                                    row_base_next = row_base_reg - RB_W'(COLUMNS);
                                end
                                else
                                begin
                                    col_next = col_reg - 1'b1;
                                end
                            end
                            state_next = ST_BS_RD;
                        end
                        K_CLEAR:
                        begin
                            row_base_next = '0;
                            col_next      = '0;
                            ptr_next      = '0;
                            state_next    = ST_WIPE;
                        end
                        K_READ:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = AW'(q_data.idx);
                            state_next = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCROLL:
            begin
                // read row below while writing the cell fetched last cycle
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = rdata_reg;
                end
                if (ptr_reg != RB_W'(CELLS))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg[AW-1:0];
                    pend_next = 1'b1;
                    dst_next  = AW'(ptr_reg - RB_W'(COLUMNS));
                    ptr_next  = ptr_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        ptr_next   = RB_W'(LAST_ROW);
                        state_next = ST_WIPE;
                    end
                end
            end

            ST_WIPE:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[AW-1:0];
                if (ptr_reg == RB_W'(CELLS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            ST_BS_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = cursor_addr;
                state_next = ST_BS_CHK;
            end

            ST_BS_CHK:
            begin
                if (seek_reg && (rdata_reg.ch == CH_NUL) && (cursor != '0))
                begin
                    // empty cell: keep walking back
                    if (col_reg == '0)
                    begin
                        col_next      = COL_W'(COLUMNS - 1);
                        row_base_next = row_base_reg - RB_W'(COLUMNS);
                    end
                    else
                    begin
                        col_next = col_reg - 1'b1;
                    end
                    state_next = ST_BS_RD;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = cursor_addr;
                    mem_wdata  = '{bg: rdata_reg.bg, fg: rdata_reg.fg, ch: CH_NUL};
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (load_out)
                begin
                    rsp_valid_next = 1'b1;
                    pos_out_next   = POS_W'(cursor);
                    cell_out_next  = (kind_reg == K_READ) ? rdata_reg : '0;
                    scr_out_next   = scrolled_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            row_base_reg  <= '0;
            col_reg       <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_base_reg  <= row_base_next;
            col_reg       <= col_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        seek_reg     <= seek_next;
        scrolled_reg <= scrolled_next;
        dst_reg      <= dst_next;
        pos_out_reg  <= pos_out_next;
        cell_out_reg <= cell_out_next;
        scr_out_reg  <= scr_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= screen_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/text_console_writer.sv @@
// a word taken goes into the queue; the back end pops it when idle and answers it
// from its output register, stalling in its done state until an earlier answer is taken
// print, tab, newline, nul, read and unused codes pass through the idle and done states;
// backspace also reads and checks a cell, again for each empty cell walked over; scroll
// and clear are both set by the single write port; reset: cursor to 0, colors to 15/0,
// then a wipe of all COLUMNS*ROWS cells of the memory during which cmd.ready stays low
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tcw_cmd_if.sink                        cmd,
    tcw_rsp_if.source                      rsp,
    input  logic                           cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    // color registers; the user must write them only while the block is quiet, the block does not enforce it
    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;

    // front to queue
    logic    q_push;
    tcw_op_t q_din;
    logic    q_full;

    // queue to back
    logic    q_valid;
    logic    q_pop;
    tcw_op_t q_dout;

    // back end holds off the front during the power-up wipe
    logic    init_busy;

    always_comb
    begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FG:  fg_next = cfg_wdata;
                REG_BG:  bg_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end
        else
        begin
            fg_reg <= fg_next;
            bg_reg <= bg_next;
        end
    end

    // front: takes words and sorts them into operation kinds
    tcw_front #(
        .CELLS (CELLS)
    ) u_front (
        .cmd       (cmd),
        .q_full    (q_full),
        .init_busy (init_busy),
        .q_push    (q_push),
        .q_data    (q_din)
    );

    // short queue so the front keeps taking words while the back is busy
    tcw_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_dout)
    );

    // back: owns the cell memory and cursor, runs scroll, wipe and backspace walks,
    // and holds the result in an output register
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_dout),
        .q_pop     (q_pop),
        .fg        (fg_reg),
        .bg        (bg_reg),
        .init_busy (init_busy),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
